// File: design/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants, state type and control structs of the text console
// cursor and scroll engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int CELL_COUNT   = COLUMNS * ROWS;
	localparam int ADDR_W       = $clog2(CELL_COUNT);
	localparam int COL_W        = $clog2(COLUMNS);
	localparam int CELL_W       = 16;
	localparam int CHAR_W       = 9;
	localparam int ATTR_W       = 8;
	localparam int SCROLL_LIMIT = (ROWS - 1) * COLUMNS;
	localparam int ZERO_START   = (ROWS - 2) * COLUMNS;

	localparam logic              OP_PUT         = 1'b0;
	localparam logic              OP_READ        = 1'b1;
	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = CHAR_W'(10);
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = CHAR_W'(256);
	localparam logic [7:0]        BLANK_CHAR     = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;
	localparam logic [CELL_W-1:0] CELL_RESET     = 16'h0720;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUT,
		ST_CHECK,
		ST_COPY,
		ST_ZERO,
		ST_BLANK,
		ST_DONE
	} tccs_state_t;

	typedef struct packed {
		logic accept;
		logic fill;
		logic put;
		logic check;
		logic copy;
		logic zero;
		logic blank;
		logic result_load;
	} tccs_cmd_t;

	typedef struct packed {
		logic in_read;
		logic fill_last;
		logic need_scroll;
		logic copy_last;
		logic zero_last;
		logic out_free;
	} tccs_sts_t;

endpackage

// File: design/tccs_ram.sv
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tccs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Controller state machine that sequences fill, put, scroll and read steps.
// ----------------------------------------------------------------------------
module tccs_ctrl
	import tccs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tccs_sts_t sts,
	output tccs_cmd_t cmd
);

	tccs_state_t state_q;
	tccs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.in_read ? ST_DONE : ST_PUT;
				end
			end
			ST_PUT: begin
				cmd.put = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.need_scroll ? ST_COPY : ST_DONE;
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_last) begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				cmd.zero = 1'b1;
				if (sts.zero_last) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				cmd.blank = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// File: design/tccs_dp.sv
// ----------------------------------------------------------------------------
// tccs_dp
// Datapath with the cell store, cursor, attribute, sweep counter and the
// result register.
// ----------------------------------------------------------------------------
module tccs_dp
	import tccs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ATTR_W-1:0] cfg_wr_data,
	input  logic              operation,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ADDR_W-1:0] read_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] cursor_pos,
	output logic [CELL_W-1:0] cell_value,
	input  tccs_cmd_t         cmd,
	output tccs_sts_t         sts
);

	logic [ATTR_W-1:0] attr_q;
	logic [ADDR_W-1:0] pos_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] cursor_pos_q;
	logic [CELL_W-1:0] cell_value_q;

	logic              op_q;
	logic [CHAR_W-1:0] code_q;
	logic              range_ok_q;

	logic              is_newline;
	logic              is_backspace;
	logic              cnt_end;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CELL_W-1:0] wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [CELL_W-1:0] rd_data;

	assign is_newline   = (code_q == CODE_NEWLINE);
	assign is_backspace = (code_q == CODE_BACKSPACE);
	assign cnt_end      = (cnt_q == ADDR_W'(CELL_COUNT - 1));

	assign sts.in_read     = (operation == OP_READ);
	assign sts.fill_last   = cnt_end;
	assign sts.zero_last   = cnt_end;
	assign sts.copy_last   = (cnt_q == ADDR_W'(ZERO_START));
	assign sts.need_scroll = (pos_q >= ADDR_W'(SCROLL_LIMIT));
	assign sts.out_free    = !out_valid_q || out_ready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = '0;
		priority if (cmd.fill) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
			wr_data = CELL_RESET;
		end else if (cmd.put) begin
			wr_en   = !is_newline && !is_backspace;
			wr_data = {attr_q, code_q[7:0]};
		end else if ((cmd.check && !sts.need_scroll) || cmd.blank) begin
			wr_en   = 1'b1;
			wr_data = {attr_q, BLANK_CHAR};
		end else if (cmd.copy) begin
			wr_en   = (cnt_q != '0);
			wr_addr = cnt_q - ADDR_W'(1);
			wr_data = rd_data;
		end else if (cmd.zero) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = read_index;
		if (cmd.accept) begin
			rd_en = (operation == OP_READ) && (read_index < ADDR_W'(CELL_COUNT));
		end else if (cmd.copy) begin
			rd_en   = !sts.copy_last;
			rd_addr = cnt_q + ADDR_W'(COLUMNS);
		end
	end

	tccs_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_cells (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RESET;
			pos_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				attr_q <= cfg_wr_data;
			end
			if (cmd.fill || cmd.zero) begin
				cnt_q <= cnt_end ? '0 : cnt_q + ADDR_W'(1);
			end else if (cmd.copy && !sts.copy_last) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			if (cmd.put) begin
				priority if (is_newline) begin
					pos_q <= pos_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
					col_q <= '0;
				end else if (is_backspace) begin
					if (pos_q != '0) begin
						pos_q <= pos_q - ADDR_W'(1);
						col_q <= (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - COL_W'(1);
					end
				end else begin
					pos_q <= pos_q + ADDR_W'(1);
					col_q <= (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
				end
			end else if (cmd.check && sts.need_scroll) begin
				pos_q <= pos_q - ADDR_W'(COLUMNS);
			end
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= operation;
			code_q     <= char_code;
			range_ok_q <= (read_index < ADDR_W'(CELL_COUNT));
		end
		if (cmd.result_load) begin
			cursor_pos_q <= pos_q;
			cell_value_q <= (op_q == OP_READ && range_ok_q) ? rd_data : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_value = cell_value_q;

endmodule

// File: design/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console engine: cell store, linear cursor, newline, backspace and
// one-row scroll, plus single-cell reads.
// ----------------------------------------------------------------------------
// A read goes from IDLE straight to DONE; an ordinary put passes PUT and CHECK.
// A put that scrolls adds a copy sweep, a clear sweep and one blank write,
// all on the one write port of the cell store. One request is in work at a
// time; the next is taken while the previous result still waits in the
// output register. After reset all CELL_COUNT cells are filled with blanks.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
	import tccs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ATTR_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ADDR_W-1:0] read_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] cursor_pos,
	output logic [CELL_W-1:0] cell_value
);

	tccs_cmd_t cmd;
	tccs_sts_t sts;

	tccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tccs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.operation   (operation),
		.char_code   (char_code),
		.read_index  (read_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cursor_pos  (cursor_pos),
		.cell_value  (cell_value),
		.cmd         (cmd),
		.sts         (sts)
	);

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_pos < ADDR_W'(SCROLL_LIMIT)))
		else $error("cursor beyond the last usable row");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in work");

endmodule
